/* rtl/core/lcdseq_pkg.sv */
package lcdseq_pkg;

    localparam int TIMER_BITS  = 20;
    localparam int CFG_W       = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int INIT_COUNT  = 5;

    // request kinds on the input channel
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE  = 2'd0;
    localparam logic [1:0] REG_GAP    = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;
    localparam logic [1:0] REG_POWER  = 2'd3;

    localparam logic [CFG_W-1:0] PULSE_RST  = CFG_W'(1000);
    localparam logic [CFG_W-1:0] GAP_RST    = CFG_W'(200000);
    localparam logic [CFG_W-1:0] SETTLE_RST = CFG_W'(2000);
    localparam logic [CFG_W-1:0] POWER_RST  = CFG_W'(20000);

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'h40;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER,
        PH_HI,
        PH_GAP,
        PH_LO,
        PH_SETTLE,
        PH_FINAL
    } phase_t;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_BYTE,
        REQ_INIT
    } req_t;

    typedef struct packed {
        req_t       req;
        logic [7:0] byte_val;
        logic       sel;
    } item_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // register value masked to the timer, zero stretched to one tick
    function automatic logic [TIMER_BITS-1:0] duration(input logic [CFG_W-1:0] v);
        logic [TIMER_BITS+CFG_W-1:0] ext;
        logic [TIMER_BITS-1:0]       d;
        ext = {{TIMER_BITS{1'b0}}, v};
        d   = ext[TIMER_BITS-1:0];
        if (d == '0) begin
            d = TIMER_BITS'(1);
        end
        return d;
    endfunction

endpackage

/* rtl/core/lcdseq_front.sv */
module lcdseq_front
    import lcdseq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_byte_value,
    input  logic [5:0]  s_column,
    input  logic [1:0]  s_row,
    output logic        push,
    output item_t       push_item,
    input  logic        q_ready
);

    logic  front_valid_reg, front_valid_next;
    item_t item_reg, item_next;
    logic  load;
    logic [7:0] addr;

    assign s_ready = !front_valid_reg || q_ready;
    assign load    = s_valid && s_ready;
    assign push    = front_valid_reg && q_ready;
    assign push_item = item_reg;

    assign addr = ((s_row == 2'd1) ? ROW1_BASE : 8'h00) + {2'b00, s_column};

    always_comb begin
        item_next.req      = REQ_NONE;
        item_next.byte_val = s_byte_value;
        item_next.sel      = 1'b0;
        unique case (s_kind)
            KIND_CMD: begin
                item_next.req = REQ_BYTE;
            end
            KIND_DATA: begin
                item_next.req = REQ_BYTE;
                item_next.sel = 1'b1;
            end
            KIND_CURSOR: begin
                item_next.req      = REQ_BYTE;
                item_next.byte_val = CMD_SET_DDRAM | addr;
            end
            KIND_INIT: begin
                item_next.req = REQ_INIT;
            end
            default: begin
                item_next.req = REQ_NONE;
            end
        endcase
    end

    always_comb begin
        front_valid_next = front_valid_reg;
        if (load) begin
            front_valid_next = 1'b1;
        end else if (push) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/core/lcdseq_queue.sv */
module lcdseq_queue
    import lcdseq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  q_ready,
    input  logic  pop,
    output item_t pop_item,
    output logic  q_valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/lcdseq_back.sv */
module lcdseq_back
    import lcdseq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             q_valid,
    input  item_t            pop_item,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_data_nibble,
    output logic             m_reg_select,
    output logic             m_enable_line,
    output logic             m_busy_res,
    output logic             m_accepted
);

    logic [CFG_W-1:0] pulse_reg, gap_reg, settle_reg, power_reg;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] wait_reg, wait_next, wait_dec;
    logic [7:0]            byte_reg, byte_next;
    logic                  sel_reg, sel_next;
    logic [2:0]            step_reg, step_next;
    logic [3:0]            nibble_reg, nibble_next;
    logic                  acc_next;

    logic       out_valid_reg, out_valid_next;
    logic [3:0] res_nibble_reg, res_nibble;
    logic       res_sel_reg, res_sel;
    logic       res_en_reg, res_en;
    logic       res_busy_reg, res_busy;
    logic       res_acc_reg;

    assign pop = q_valid && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg  <= PULSE_RST;
            gap_reg    <= GAP_RST;
            settle_reg <= SETTLE_RST;
            power_reg  <= POWER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PULSE:  pulse_reg  <= cfg_wr_data;
                REG_GAP:    gap_reg    <= cfg_wr_data;
                REG_SETTLE: settle_reg <= cfg_wr_data;
                REG_POWER:  power_reg  <= cfg_wr_data;
                default:    pulse_reg  <= pulse_reg;
            endcase
        end
    end

    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;

    // next state: one beat moves the sequencer by one tick
    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        sel_next    = sel_reg;
        step_next   = step_reg;
        nibble_next = nibble_reg;
        acc_next    = 1'b0;
        if (pop) begin
            if (phase_reg == PH_IDLE) begin
                unique case (pop_item.req)
                    REQ_BYTE: begin
                        byte_next   = pop_item.byte_val;
                        sel_next    = pop_item.sel;
                        nibble_next = pop_item.byte_val[7:4];
                        phase_next  = PH_HI;
                        wait_next   = duration(pulse_reg);
                        acc_next    = 1'b1;
                    end
                    REQ_INIT: begin
                        step_next  = 3'd0;
                        phase_next = PH_POWER;
                        wait_next  = duration(power_reg);
                        acc_next   = 1'b1;
                    end
                    default: begin
                        acc_next = 1'b0;
                    end
                endcase
            end else begin
                wait_next = wait_dec;
                if (wait_dec == '0) begin
                    unique case (phase_reg)
                        PH_POWER: begin
                            step_next   = 3'd1;
                            byte_next   = init_byte(3'd0);
                            sel_next    = 1'b0;
                            nibble_next = 4'(init_byte(3'd0) >> 4);
                            phase_next  = PH_HI;
                            wait_next   = duration(pulse_reg);
                        end
                        PH_HI: begin
                            phase_next = PH_GAP;
                            wait_next  = duration(gap_reg);
                        end
                        PH_GAP: begin
                            nibble_next = byte_reg[3:0];
                            phase_next  = PH_LO;
                            wait_next   = duration(pulse_reg);
                        end
                        PH_LO: begin
                            phase_next = PH_SETTLE;
                            wait_next  = duration(settle_reg);
                        end
                        PH_SETTLE: begin
                            if (step_reg >= 3'd1 && step_reg < 3'(INIT_COUNT)) begin
                                byte_next   = init_byte(step_reg);
                                sel_next    = 1'b0;
                                nibble_next = 4'(init_byte(step_reg) >> 4);
                                phase_next  = PH_HI;
                                wait_next   = duration(pulse_reg);
                                step_next   = step_reg + 1'b1;
                            end else if (step_reg == 3'(INIT_COUNT)) begin
                                step_next  = 3'd0;
                                phase_next = PH_FINAL;
                                wait_next  = duration(settle_reg);
                            end else begin
                                step_next  = 3'd0;
                                phase_next = PH_IDLE;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            wait_next  = '0;
                        end
                    endcase
                end
            end
        end
    end

    // result fields follow the state after this tick
    always_comb begin
        res_nibble = nibble_next;
        res_sel    = sel_next;
        res_en     = (phase_next == PH_HI) || (phase_next == PH_LO);
        res_busy   = (phase_next != PH_IDLE);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            byte_reg      <= '0;
            sel_reg       <= 1'b0;
            step_reg      <= '0;
            nibble_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            byte_reg      <= byte_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            nibble_reg    <= nibble_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_nibble_reg <= res_nibble;
            res_sel_reg    <= res_sel;
            res_en_reg     <= res_en;
            res_busy_reg   <= res_busy;
            res_acc_reg    <= acc_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data_nibble = res_nibble_reg;
    assign m_reg_select  = res_sel_reg;
    assign m_enable_line = res_en_reg;
    assign m_busy_res    = res_busy_reg;
    assign m_accepted    = res_acc_reg;

endmodule

/* rtl/core/char_lcd_nibble_write_sequencer.sv */
// An accepted beat passes the decode register, the two-entry queue and the
// sequencer with its output register before its result beat appears.
// Throughput: one beat per cycle while m_ready does not stall; the sequencer
// advances one tick per beat. Reset (aresetn low, synchronous): sequencer
// idle, queue and output empty, timing registers back to their defaults.
module char_lcd_nibble_write_sequencer
    import lcdseq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_kind,
    input  logic [7:0]       s_byte_value,
    input  logic [5:0]       s_column,
    input  logic [1:0]       s_row,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_data_nibble,
    output logic             m_reg_select,
    output logic             m_enable_line,
    output logic             m_busy_res,
    output logic             m_accepted
);

    logic  push, q_ready, pop, q_valid;
    item_t push_item, pop_item;

    lcdseq_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_byte_value (s_byte_value),
        .s_column     (s_column),
        .s_row        (s_row),
        .push         (push),
        .push_item    (push_item),
        .q_ready      (q_ready)
    );

    lcdseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_valid   (q_valid)
    );

    lcdseq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_nibble (m_data_nibble),
        .m_reg_select  (m_reg_select),
        .m_enable_line (m_enable_line),
        .m_busy_res    (m_busy_res),
        .m_accepted    (m_accepted)
    );

endmodule

/* rtl/core/lcdseq_checker.sv */
module lcdseq_checker
    import lcdseq_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_data_nibble,
    input logic       m_reg_select,
    input logic       m_enable_line,
    input logic       m_busy_res,
    input logic       m_accepted
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_nibble)
            && $stable(m_reg_select) && $stable(m_enable_line))
        else $error("result beat changed while stalled");

    // strobe only during a byte transfer
    a_en_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_enable_line |-> m_busy_res)
        else $error("enable high while not busy");

    // every taken request starts a busy sequence
    a_acc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_busy_res)
        else $error("accepted request without busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_nibble (m_data_nibble),
    .m_reg_select  (m_reg_select),
    .m_enable_line (m_enable_line),
    .m_busy_res    (m_busy_res),
    .m_accepted    (m_accepted)
);

/* tb/lcd_bus_checker.sv */
module lcd_bus_checker
    import lcdseq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [2:0]       s_kind,
    input  logic [7:0]       s_byte_value,
    input  logic [5:0]       s_column,
    input  logic [1:0]       s_row,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [3:0]       m_data_nibble,
    input  logic             m_reg_select,
    input  logic             m_enable_line,
    input  logic             m_busy_res,
    input  logic             m_accepted,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic       en;
        logic       busy;
        logic       taken;
    } lcd_bus_t;

    // power-up command bytes, first one sent in the top byte
    localparam logic [8*INIT_COUNT-1:0] BOOT_SEQ = 40'h02_28_0C_06_01;

    logic [CFG_W-1:0]      pulse_len;
    logic [CFG_W-1:0]      gap_len;
    logic [CFG_W-1:0]      settle_len;
    logic [CFG_W-1:0]      power_len;

    phase_t                seq_phase;
    logic [TIMER_BITS-1:0] ticks_left;
    logic [7:0]            held_byte;
    logic                  held_rs;
    logic [2:0]            boot_idx;
    logic [3:0]            bus_out;

    lcd_bus_t              bus_expected[$];

    // timer load: keep the low TIMER_BITS, a zero still lasts one tick
    function automatic logic [TIMER_BITS-1:0] ticks_of(input logic [CFG_W-1:0] v);
        logic [TIMER_BITS-1:0] t;
        t = TIMER_BITS'(v);
        return (t == '0) ? TIMER_BITS'(1) : t;
    endfunction

    task automatic load_byte(input logic [7:0] b, input logic rs);
        held_byte  = b;
        held_rs    = rs;
        bus_out    = b[7:4];
        seq_phase  = PH_HI;
        ticks_left = ticks_of(pulse_len);
    endtask

    task automatic run_tick();
        if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
        end
        if (ticks_left == '0) begin
            case (seq_phase)
                PH_POWER: begin
                    boot_idx = 3'd1;
                    load_byte(BOOT_SEQ[8*(INIT_COUNT-1) +: 8], 1'b0);
                end
                PH_HI: begin
                    seq_phase  = PH_GAP;
                    ticks_left = ticks_of(gap_len);
                end
                PH_GAP: begin
                    bus_out    = held_byte[3:0];
                    seq_phase  = PH_LO;
                    ticks_left = ticks_of(pulse_len);
                end
                PH_LO: begin
                    seq_phase  = PH_SETTLE;
                    ticks_left = ticks_of(settle_len);
                end
                PH_SETTLE: begin
                    if (boot_idx >= 1 && boot_idx < INIT_COUNT) begin
                        load_byte(BOOT_SEQ[8*(INIT_COUNT-1-boot_idx) +: 8], 1'b0);
                        boot_idx = boot_idx + 1'b1;
                    end else if (boot_idx == INIT_COUNT) begin
                        // init done, one more settle wait before idle
                        boot_idx   = '0;
                        seq_phase  = PH_FINAL;
                        ticks_left = ticks_of(settle_len);
                    end else begin
                        boot_idx  = '0;
                        seq_phase = PH_IDLE;
                    end
                end
                default: begin
                    seq_phase  = PH_IDLE;
                    ticks_left = '0;
                end
            endcase
        end
    endtask

    // one input beat is one sequencer tick; requests only land when idle
    task automatic predict_beat(input logic [2:0] kind, input logic [7:0] bval,
                                input logic [5:0] col, input logic [1:0] row,
                                output lcd_bus_t res);
        logic taken;
        logic [7:0] addr;
        taken = 1'b0;
        if (seq_phase == PH_IDLE) begin
            taken = 1'b1;
            case (kind)
                KIND_CMD:    load_byte(bval, 1'b0);
                KIND_DATA:   load_byte(bval, 1'b1);
                KIND_CURSOR: begin
                    addr = ((row == 2'd1) ? ROW1_BASE : 8'h00) + {2'b00, col};
                    load_byte(CMD_SET_DDRAM | addr, 1'b0);
                end
                KIND_INIT: begin
                    boot_idx   = '0;
                    seq_phase  = PH_POWER;
                    ticks_left = ticks_of(power_len);
                end
                default:     taken = 1'b0;
            endcase
        end else begin
            run_tick();
        end
        res = {bus_out, held_rs, (seq_phase == PH_HI || seq_phase == PH_LO),
               (seq_phase != PH_IDLE), taken};
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        lcd_bus_t seen;
        lcd_bus_t want;
        if (!aresetn) begin
            pulse_len  = PULSE_RST;
            gap_len    = GAP_RST;
            settle_len = SETTLE_RST;
            power_len  = POWER_RST;
            seq_phase  = PH_IDLE;
            ticks_left = '0;
            held_byte  = '0;
            held_rs    = 1'b0;
            boot_idx   = '0;
            bus_out    = '0;
            bus_expected.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_data_nibble, m_reg_select, m_enable_line, m_busy_res, m_accepted};
                if (bus_expected.size() == 0) begin
                    $display("%0t ns: result beat expected none, got %h", $time, seen);
                    mismatches++;
                end else begin
                    want = bus_expected.pop_front();
                    check_field("data_nibble", want.nibble, seen.nibble);
                    check_field("reg_select", want.rs, seen.rs);
                    check_field("enable_line", want.en, seen.en);
                    check_field("busy_res", want.busy, seen.busy);
                    check_field("accepted", want.taken, seen.taken);
                end
            end
            if (s_valid && s_ready) begin
                predict_beat(s_kind, s_byte_value, s_column, s_row, want);
                bus_expected.push_back(want);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PULSE:  pulse_len  = cfg_wr_data;
                    REG_GAP:    gap_len    = cfg_wr_data;
                    REG_SETTLE: settle_len = cfg_wr_data;
                    REG_POWER:  power_len  = cfg_wr_data;
                    default:    ;
                endcase
            end
        end
        outstanding = bus_expected.size();
    end

endmodule

/* tb/char_lcd_nibble_write_sequencer_test.sv */
module char_lcd_nibble_write_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdseq_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAD   = 4;
    localparam int END_PAD     = 12;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [2:0]       s_kind;
    logic [7:0]       s_byte_value;
    logic [5:0]       s_column;
    logic [1:0]       s_row;
    logic             m_valid;
    logic             m_ready;
    logic [3:0]       m_data_nibble;
    logic             m_reg_select;
    logic             m_enable_line;
    logic             m_busy_res;
    logic             m_accepted;

    int               mismatches;
    int               outstanding;

    logic             src_gaps = 1'b0;
    logic             sink_gaps = 1'b0;
    int               holds_asked = 0;
    int               holds_served = 0;
    int               idle_cycles = 0;

    char_lcd_nibble_write_sequencer DUT (.*);

    lcd_bus_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random back-pressure plus long hold-offs on request
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (holds_asked > holds_served) begin
                holds_served++;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end else begin
                m_ready <= !(sink_gaps && $urandom_range(0, 99) < 21);
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_beat(input logic [2:0] kind, input logic [7:0] bval,
                             input logic [5:0] col, input logic [1:0] row);
        while (src_gaps && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_byte_value <= bval;
        s_column     <= col;
        s_row        <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_beat(KIND_TICK, 8'($urandom), 6'($urandom), 2'($urandom));
    endtask

    task automatic request(input logic [2:0] kind, input logic [7:0] bval,
                           input logic [5:0] col, input logic [1:0] row, input int ticks);
        send_beat(kind, bval, col, row);
        idle_ticks(ticks);
    endtask

    task automatic send_random_beat();
        int         pick;
        logic [2:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 48)      kind = KIND_TICK;
        else if (pick < 52) kind = 3'(KIND_INIT + $urandom_range(1, 3));
        else if (pick < 67) kind = KIND_CMD;
        else if (pick < 82) kind = KIND_DATA;
        else if (pick < 96) kind = KIND_CURSOR;
        else                kind = KIND_INIT;
        send_beat(kind, 8'($urandom), 6'($urandom), 2'($urandom));
    endtask

    task automatic run_phase(input int n, input int hold_at);
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) begin
                holds_asked++;
            end
            send_random_beat();
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] gap,
                              input logic [CFG_W-1:0] settle, input logic [CFG_W-1:0] power);
        wait_drained();
        write_reg(REG_PULSE, pulse);
        write_reg(REG_GAP, gap);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_POWER, power);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_TICK;
        s_byte_value = '0;
        s_column     = '0;
        s_row        = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_PULSE;
        cfg_wr_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // a byte takes 5 ticks here, init about 30
        set_timing(1, 2, 1, 3);
        request(KIND_CMD, 8'h00, 6'd0, 2'd0, 6);
        request(KIND_CMD, 8'hFF, 6'd63, 2'd3, 6);
        request(KIND_DATA, 8'h00, 6'd0, 2'd0, 6);
        request(KIND_DATA, 8'hFF, 6'd63, 2'd3, 6);
        request(KIND_DATA, 8'h5A, 6'd0, 2'd0, 0);
        request(KIND_DATA, 8'hA5, 6'd0, 2'd0, 6);     // lands while busy
        request(KIND_CURSOR, 8'h00, 6'd0, 2'd0, 6);
        request(KIND_CURSOR, 8'hFF, 6'd63, 2'd1, 6);
        request(KIND_CURSOR, 8'h00, 6'd0, 2'd1, 6);
        request(KIND_CURSOR, 8'h00, 6'd63, 2'd0, 6);
        request(KIND_CURSOR, 8'h00, 6'd21, 2'd2, 6);
        request(KIND_CURSOR, 8'h00, 6'd42, 2'd3, 6);
        request(KIND_INIT, 8'h00, 6'd0, 2'd0, 4);
        request(KIND_CMD, 8'h33, 6'd0, 2'd0, 15);     // refused during init
        for (int k = KIND_INIT + 1; k < 8; k++) begin
            request(3'(k), 8'hFF, 6'd63, 2'd3, 1);
        end
        request(KIND_TICK, 8'hFF, 6'd63, 2'd3, 1);
        // next request hits the tick where the final wait ends
        request(KIND_CMD, 8'h3C, 6'd0, 2'd0, 4);
        request(KIND_DATA, 8'hC3, 6'd0, 2'd0, 6);

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        set_timing(1, 1, 1, 1);
        run_phase(200, -1);
        idle_ticks(40);

        // max values written but never loaded: only non-requests while idle
        set_timing(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        repeat (12) begin
            send_beat(($urandom_range(0, 3) == 0) ? KIND_TICK
                                                  : 3'(KIND_INIT + $urandom_range(1, 3)),
                      8'($urandom), 6'($urandom), 2'($urandom));
        end

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        set_timing(0, 0, 0, 0);
        run_phase(250, -1);

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        set_timing(20'($urandom_range(1, 5)), 20'($urandom_range(1, 5)),
                   20'($urandom_range(1, 5)), 20'($urandom_range(1, 5)));
        run_phase(250, 120);

        set_timing(30, 45, 20, 60);
        run_phase(150, -1);

        sink_gaps = 1'b0;
        set_timing(20'($urandom_range(1, 8)), 20'($urandom_range(1, 8)),
                   20'($urandom_range(1, 8)), 20'($urandom_range(1, 8)));
        run_phase(200, 100);

        sink_gaps = 1'b1;
        set_timing(2, 1, 3, 2);
        run_phase(150, -1);

        wait_drained();
        repeat (END_PAD) @(negedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
